@@ rtl/line_pair_angle_intersect_unit_assert.svh @@
// Assertion macros for the line pair angle and intersection unit.
// Included by the modules that carry concurrent assertions; no dependencies.
`ifndef LINE_PAIR_ANGLE_INTERSECT_UNIT_ASSERT_SVH
`define LINE_PAIR_ANGLE_INTERSECT_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Clocked check that is switched off while reset is held.
`define LPAI_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("line pair unit: assertion failed");

// Clocked check that also runs during reset.
`define LPAI_ASSERT_NR(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("line pair unit: assertion failed");

`else

`define LPAI_ASSERT(lbl, clk, rst_n, prop)
`define LPAI_ASSERT_NR(lbl, clk, prop)

`endif

`endif

@@ rtl/lpai_pkg.sv @@
// Shared widths, types and functions of the line pair angle and intersection unit.
// No dependencies; imported by every module of the unit.
package lpai_pkg;

    // Coordinate and intermediate widths.
    localparam int IN_W     = 20;
    localparam int DLT_W    = IN_W + 1;
    localparam int PRD_W    = 2 * DLT_W;
    localparam int SUM_W    = PRD_W + 1;
    localparam int VEC_W    = SUM_W + 1;
    localparam int MUL_W    = SUM_W + DLT_W;
    localparam int Q_W      = 22;
    localparam int DIV_W    = SUM_W + 1;
    localparam int REM_W    = DIV_W + Q_W;
    localparam int ANG_W    = 17;

    // Angle accumulator and CORDIC chain.
    localparam int Z_W          = 32;
    localparam int ACC_FRAC     = 20;
    localparam int ANGLE_FRAC   = 8;
    localparam int ROUND_SH     = ACC_FRAC - ANGLE_FRAC;
    localparam int CORDIC_STEPS = 24;
    localparam int NORM_STAGES  = 6;
    localparam int NORM_TOP     = 41;

    // Pipeline depths counted from the third input stage.
    localparam int ANG_PIPE = 1 + NORM_STAGES + CORDIC_STEPS;
    localparam int VTX_PIPE = Q_W + 3;
    localparam int VTX_DLY  = ANG_PIPE - VTX_PIPE;
    localparam int LAT      = 3 + ANG_PIPE + 1;

    localparam logic signed [Z_W-1:0] Z_90       = Z_W'(90 * (1 << ACC_FRAC));
    localparam logic signed [Z_W-1:0] Z_180      = Z_W'(180 * (1 << ACC_FRAC));
    localparam logic signed [Z_W-1:0] ROUND_HALF = Z_W'(1 << (ROUND_SH - 1));
    localparam logic signed [Z_W-1:0] HALF_TURN  = Z_W'(180 * (1 << ANGLE_FRAC));
    localparam logic signed [Z_W-1:0] FULL_TURN  = Z_W'(360 * (1 << ANGLE_FRAC));
    localparam logic signed [IN_W-1:0] V_MAX = {1'b0, {(IN_W-1){1'b1}}};
    localparam logic signed [IN_W-1:0] V_MIN = {1'b1, {(IN_W-1){1'b0}}};

    // Vector moving through the atan2 chain.
    typedef struct packed {
        logic                    hold;
        logic signed [VEC_W-1:0] x;
        logic signed [VEC_W-1:0] y;
        logic [VEC_W-1:0]        m;
        logic signed [Z_W-1:0]   z;
    } t_vec;

    // Partial remainder and quotient moving through the divider chain.
    typedef struct packed {
        logic [REM_W-1:0] r;
        logic [DIV_W-1:0] d;
        logic [Q_W-1:0]   q;
    } t_div;

    // Vertex side information that rides along the divider chain.
    typedef struct packed {
        logic                   has;
        logic                   neg_x;
        logic                   neg_y;
        logic                   big_x;
        logic                   big_y;
        logic signed [IN_W-1:0] x1;
        logic signed [IN_W-1:0] y1;
    } t_vside;

    // Finished vertex.
    typedef struct packed {
        logic                   has;
        logic                   clip;
        logic signed [IN_W-1:0] vx;
        logic signed [IN_W-1:0] vy;
    } t_vtx;

    typedef struct packed {
        logic                   clip;
        logic signed [IN_W-1:0] v;
    } t_lane;

    // atan(2^-i) in degrees scaled by 2^20.
    function automatic logic signed [Z_W-1:0] atan_lut(input int idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            0:  v = Z_W'(47185920);
            1:  v = Z_W'(27855475);
            2:  v = Z_W'(14718068);
            3:  v = Z_W'(7471121);
            4:  v = Z_W'(3750058);
            5:  v = Z_W'(1876857);
            6:  v = Z_W'(938658);
            7:  v = Z_W'(469357);
            8:  v = Z_W'(234682);
            9:  v = Z_W'(117342);
            10: v = Z_W'(58671);
            11: v = Z_W'(29335);
            12: v = Z_W'(14668);
            13: v = Z_W'(7334);
            14: v = Z_W'(3667);
            15: v = Z_W'(1833);
            16: v = Z_W'(917);
            17: v = Z_W'(458);
            18: v = Z_W'(229);
            19: v = Z_W'(115);
            20: v = Z_W'(57);
            21: v = Z_W'(29);
            22: v = Z_W'(14);
            23: v = Z_W'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

    // Exact axis cases and quadrant pre-rotation ahead of the CORDIC chain.
    function automatic t_vec vec_pre(input logic signed [VEC_W-1:0] y,
                                     input logic signed [VEC_W-1:0] x);
        t_vec             v;
        logic [VEC_W-1:0] ax;
        logic [VEC_W-1:0] ay;
        v.hold = 1'b0;
        v.x    = x;
        v.y    = y;
        v.z    = '0;
        if (y == 0) begin
            v.hold = 1'b1;
            v.z    = (x < 0) ? Z_180 : '0;
        end else if (x == 0) begin
            v.hold = 1'b1;
            v.z    = (y > 0) ? Z_90 : -Z_90;
        end else if (x < 0) begin
            if (y > 0) begin
                v.x = y;
                v.y = -x;
                v.z = Z_90;
            end else begin
                v.x = -y;
                v.y = x;
                v.z = -Z_90;
            end
        end
        ax  = v.x[VEC_W-1] ? -v.x : v.x;
        ay  = v.y[VEC_W-1] ? -v.y : v.y;
        v.m = (ax > ay) ? ax : ay;
        return v;
    endfunction

    // Round the accumulator to the output angle grid, halves upward.
    function automatic logic signed [Z_W-1:0] round_ang(input logic signed [Z_W-1:0] z);
        return (z + ROUND_HALF) >>> ROUND_SH;
    endfunction

    // Add the signed quotient to the base point and saturate.
    function automatic t_lane vtx_lane(input logic signed [IN_W-1:0] base,
                                       input logic [Q_W-1:0] q,
                                       input logic neg, input logic big);
        t_lane                 res;
        logic signed [Q_W+1:0] off;
        logic signed [Q_W+1:0] sum;
        off = $signed({2'b00, q});
        if (neg) begin
            off = -off;
        end
        sum      = (Q_W+2)'(base) + off;
        res.clip = 1'b0;
        res.v    = sum[IN_W-1:0];
        if (big) begin
            res.clip = 1'b1;
            res.v    = neg ? V_MIN : V_MAX;
        end else if (sum > (Q_W+2)'(V_MAX)) begin
            res.clip = 1'b1;
            res.v    = V_MAX;
        end else if (sum < (Q_W+2)'(V_MIN)) begin
            res.clip = 1'b1;
            res.v    = V_MIN;
        end
        return res;
    endfunction

endpackage

@@ rtl/lpai_norm_cell.sv @@
// Normalization cell: shifts the vector left by a fixed amount when it is still short.
// Depends on lpai_pkg.
module lpai_norm_cell
    import lpai_pkg::*;
#(
    parameter int SHIFT = 1
) (
    input  logic i_clk,
    input  logic i_en,
    input  t_vec i_vec,
    output t_vec o_vec
);

    t_vec r_vec;
    t_vec n_vec;

    // Shift only if the larger component stays below the normalization ceiling.
    always_comb begin
        n_vec = i_vec;
        if (!i_vec.hold && ((i_vec.m >> (NORM_TOP - SHIFT)) == '0)) begin
            n_vec.x = i_vec.x <<< SHIFT;
            n_vec.y = i_vec.y <<< SHIFT;
            n_vec.m = i_vec.m << SHIFT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= n_vec;
        end
    end

    assign o_vec = r_vec;

endmodule

@@ rtl/lpai_cordic_cell.sv @@
// CORDIC vectoring cell: one micro-rotation with a fixed shift and angle constant.
// Depends on lpai_pkg.
module lpai_cordic_cell
    import lpai_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic i_clk,
    input  logic i_en,
    input  t_vec i_vec,
    output t_vec o_vec
);

    t_vec                    r_vec;
    t_vec                    n_vec;
    logic signed [VEC_W-1:0] xs;
    logic signed [VEC_W-1:0] ys;

    // Rotate toward the x axis; shifts round toward minus infinity.
    always_comb begin
        n_vec = i_vec;
        xs    = i_vec.x >>> IDX;
        ys    = i_vec.y >>> IDX;
        if (!i_vec.hold) begin
            if (i_vec.y > 0) begin
                n_vec.x = i_vec.x + ys;
                n_vec.y = i_vec.y - xs;
                n_vec.z = i_vec.z + atan_lut(IDX);
            end else begin
                n_vec.x = i_vec.x - ys;
                n_vec.y = i_vec.y + xs;
                n_vec.z = i_vec.z - atan_lut(IDX);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_vec <= n_vec;
        end
    end

    assign o_vec = r_vec;

endmodule

@@ rtl/lpai_div_cell.sv @@
// Restoring divider cell: decides one quotient bit at a fixed position.
// Depends on lpai_pkg.
module lpai_div_cell
    import lpai_pkg::*;
#(
    parameter int BIT = 0
) (
    input  logic i_clk,
    input  logic i_en,
    input  t_div i_div,
    output t_div o_div
);

    t_div             r_div;
    t_div             n_div;
    logic [REM_W-1:0] trial;

    // Subtract the shifted divisor when it fits.
    always_comb begin
        n_div = i_div;
        trial = REM_W'(i_div.d) << BIT;
        if (i_div.r >= trial) begin
            n_div.r      = i_div.r - trial;
            n_div.q[BIT] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_div <= n_div;
        end
    end

    assign o_div = r_div;

endmodule

@@ rtl/line_pair_angle_intersect_unit.sv @@
// Line pair angle and intersection unit: top level with front stages and cell chains.
// Depends on lpai_pkg, the cell modules and line_pair_angle_intersect_unit_assert.svh.
//
// Usage:
//   Input channel i_valid / o_stall carries one word of two lines (A and B, two
//   endpoints each). Output channel o_valid / i_stall returns one word per input
//   word: angle, vertex, has_vertex and vertex_clipped, in input order.
//   The unit is a fixed pipeline of 35 register stages. One word is accepted
//   every cycle while o_stall is low; the depth comes from three front stages,
//   one pre-rotation stage, six normalization cells, the 24-cell CORDIC chain
//   and the output register, with the 22-cell vertex divider running alongside.
//   When the last stage holds a word and i_stall is high, the whole pipeline
//   freezes and o_stall is raised; nothing is dropped or repeated.
//   i_cfg_we writes the mode bit from i_cfg_wdata; write it only while idle.
//   Synchronous reset clears all valid flags and sets the mode bit to 0.
`include "line_pair_angle_intersect_unit_assert.svh"

module line_pair_angle_intersect_unit
    import lpai_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_wdata,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  logic signed [IN_W-1:0] i_a_start_x,
    input  logic signed [IN_W-1:0] i_a_start_y,
    input  logic signed [IN_W-1:0] i_a_end_x,
    input  logic signed [IN_W-1:0] i_a_end_y,
    input  logic signed [IN_W-1:0] i_b_start_x,
    input  logic signed [IN_W-1:0] i_b_start_y,
    input  logic signed [IN_W-1:0] i_b_end_x,
    input  logic signed [IN_W-1:0] i_b_end_y,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic signed [ANG_W-1:0] o_angle,
    output logic signed [IN_W-1:0] o_vertex_x,
    output logic signed [IN_W-1:0] o_vertex_y,
    output logic                   o_has_vertex,
    output logic                   o_vertex_clipped
);

    logic           r_mode;
    logic [1:LAT]   r_vld;
    logic           w_adv;

    // Stage 1: direction vectors and start point offsets.
    logic signed [DLT_W-1:0] r1_vax, r1_vay, r1_vbx, r1_vby, r1_dx13, r1_dy13;
    logic signed [IN_W-1:0]  r1_x1, r1_y1;
    // Stage 2: products.
    logic signed [PRD_W-1:0] r2_pab, r2_pba, r2_pxx, r2_pyy, r2_pn1, r2_pn2;
    logic signed [DLT_W-1:0] r2_vax, r2_vay, r2_vbx, r2_vby;
    logic signed [IN_W-1:0]  r2_x1, r2_y1;
    // Stage 3: cross, dot, numerator and chain operands.
    logic signed [SUM_W-1:0] n3_crs, n3_dot, n3_num;
    logic signed [VEC_W-1:0] n3_cabs, n3_dabs;
    logic signed [VEC_W-1:0] r3_y0, r3_x0, r3_ya, r3_xa;
    logic signed [SUM_W-1:0] r3_crs, r3_num;
    logic signed [DLT_W-1:0] r3_vax, r3_vay;
    logic signed [IN_W-1:0]  r3_x1, r3_y1;
    // Stage 4: vertex products, chain entry.
    logic signed [MUL_W-1:0] r4_px, r4_py;
    logic signed [SUM_W-1:0] r4_crs;
    logic signed [IN_W-1:0]  r4_x1, r4_y1;
    t_vec                    r4_vb, r4_va;
    // Stage 5: divider entry.
    logic [MUL_W-1:0] n5_upx, n5_upy;
    logic [SUM_W-1:0] n5_ud;
    logic [DIV_W-1:0] n5_dd;
    logic [REM_W-1:0] n5_nx, n5_ny, n5_lim;
    t_div             n5_dx, n5_dy, r5_dx, r5_dy;
    t_vside           n5_vs;

    t_vec   w_vb [0:ANG_PIPE-1];
    t_vec   w_va [0:ANG_PIPE-1];
    t_div   w_dx [0:Q_W];
    t_div   w_dy [0:Q_W];
    t_vside r_vs [0:Q_W];
    t_vtx   r_vt [0:VTX_DLY];
    t_vtx   n_vt;
    t_lane  w_lx, w_ly;

    logic signed [Z_W-1:0]   n_ang;
    logic signed [ANG_W-1:0] r_o_angle;
    t_vtx                    r_o_vtx;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // The pipeline moves unless the finished word is held by the receiver.
    assign o_stall = r_vld[LAT] & i_stall;
    assign w_adv   = ~o_stall;
    assign o_valid = r_vld[LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld[1] <= i_valid;
            for (int k = 2; k <= LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Stages 1 and 2: differences, then the six products.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_vax  <= DLT_W'(i_a_end_x) - DLT_W'(i_a_start_x);
            r1_vay  <= DLT_W'(i_a_end_y) - DLT_W'(i_a_start_y);
            r1_vbx  <= DLT_W'(i_b_end_x) - DLT_W'(i_b_start_x);
            r1_vby  <= DLT_W'(i_b_end_y) - DLT_W'(i_b_start_y);
            r1_dx13 <= DLT_W'(i_a_start_x) - DLT_W'(i_b_start_x);
            r1_dy13 <= DLT_W'(i_a_start_y) - DLT_W'(i_b_start_y);
            r1_x1   <= i_a_start_x;
            r1_y1   <= i_a_start_y;

            r2_pab <= PRD_W'(r1_vax) * PRD_W'(r1_vby);
            r2_pba <= PRD_W'(r1_vay) * PRD_W'(r1_vbx);
            r2_pxx <= PRD_W'(r1_vax) * PRD_W'(r1_vbx);
            r2_pyy <= PRD_W'(r1_vay) * PRD_W'(r1_vby);
            r2_pn1 <= PRD_W'(r1_dx13) * PRD_W'(r1_vby);
            r2_pn2 <= PRD_W'(r1_dy13) * PRD_W'(r1_vbx);
            r2_vax <= r1_vax;
            r2_vay <= r1_vay;
            r2_vbx <= r1_vbx;
            r2_vby <= r1_vby;
            r2_x1  <= r1_x1;
            r2_y1  <= r1_y1;
        end
    end

    // Stage 3: the cross product doubles as the intersection denominator.
    always_comb begin
        n3_crs  = SUM_W'(r2_pab) - SUM_W'(r2_pba);
        n3_dot  = SUM_W'(r2_pxx) + SUM_W'(r2_pyy);
        n3_num  = SUM_W'(r2_pn2) - SUM_W'(r2_pn1);
        n3_cabs = n3_crs[SUM_W-1] ? -VEC_W'(n3_crs) : VEC_W'(n3_crs);
        n3_dabs = n3_dot[SUM_W-1] ? -VEC_W'(n3_dot) : VEC_W'(n3_dot);
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r3_y0  <= r_mode ? VEC_W'(r2_vby) : n3_cabs;
            r3_x0  <= r_mode ? VEC_W'(r2_vbx) : n3_dabs;
            r3_ya  <= VEC_W'(r2_vay);
            r3_xa  <= VEC_W'(r2_vax);
            r3_crs <= n3_crs;
            r3_num <= n3_num;
            r3_vax <= r2_vax;
            r3_vay <= r2_vay;
            r3_x1  <= r2_x1;
            r3_y1  <= r2_y1;
        end
    end

    // Stage 4: vertex numerator products and atan2 pre-rotation.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r4_px  <= MUL_W'(r3_num) * MUL_W'(r3_vax);
            r4_py  <= MUL_W'(r3_num) * MUL_W'(r3_vay);
            r4_crs <= r3_crs;
            r4_x1  <= r3_x1;
            r4_y1  <= r3_y1;
            r4_vb  <= vec_pre(r3_y0, r3_x0);
            r4_va  <= vec_pre(r3_ya, r3_xa);
        end
    end

    assign w_vb[0] = r4_vb;
    assign w_va[0] = r4_va;

    // Normalization and CORDIC chains for line B (or the pair) and line A.
    for (genvar j = 0; j < NORM_STAGES; j++) begin : g_norm
        lpai_norm_cell #(.SHIFT(1 << (NORM_STAGES - 1 - j))) u_norm_b (
            .i_clk (i_clk), .i_en (w_adv), .i_vec (w_vb[j]), .o_vec (w_vb[j+1])
        );
        lpai_norm_cell #(.SHIFT(1 << (NORM_STAGES - 1 - j))) u_norm_a (
            .i_clk (i_clk), .i_en (w_adv), .i_vec (w_va[j]), .o_vec (w_va[j+1])
        );
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        lpai_cordic_cell #(.IDX(k)) u_cordic_b (
            .i_clk (i_clk), .i_en (w_adv),
            .i_vec (w_vb[NORM_STAGES+k]), .o_vec (w_vb[NORM_STAGES+k+1])
        );
        lpai_cordic_cell #(.IDX(k)) u_cordic_a (
            .i_clk (i_clk), .i_en (w_adv),
            .i_vec (w_va[NORM_STAGES+k]), .o_vec (w_va[NORM_STAGES+k+1])
        );
    end

    // Stage 5: rounded quotient |p|/|d| becomes (2|p|+|d|)/(2|d|); huge ones saturate.
    always_comb begin
        n5_upx = r4_px[MUL_W-1] ? MUL_W'(-r4_px) : MUL_W'(r4_px);
        n5_upy = r4_py[MUL_W-1] ? MUL_W'(-r4_py) : MUL_W'(r4_py);
        n5_ud  = r4_crs[SUM_W-1] ? SUM_W'(-r4_crs) : SUM_W'(r4_crs);
        n5_dd  = DIV_W'(n5_ud) << 1;
        n5_nx  = (REM_W'(n5_upx) << 1) + REM_W'(n5_ud);
        n5_ny  = (REM_W'(n5_upy) << 1) + REM_W'(n5_ud);
        n5_lim = REM_W'(n5_dd) << Q_W;

        n5_dx  = '{r: n5_nx, d: n5_dd, q: '0};
        n5_dy  = '{r: n5_ny, d: n5_dd, q: '0};

        n5_vs.has   = (r4_crs != 0);
        n5_vs.neg_x = r4_px[MUL_W-1] ^ r4_crs[SUM_W-1];
        n5_vs.neg_y = r4_py[MUL_W-1] ^ r4_crs[SUM_W-1];
        n5_vs.big_x = (n5_nx >= n5_lim);
        n5_vs.big_y = (n5_ny >= n5_lim);
        n5_vs.x1    = r4_x1;
        n5_vs.y1    = r4_y1;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r5_dx   <= n5_dx;
            r5_dy   <= n5_dy;
            r_vs[0] <= n5_vs;
            for (int k = 1; k <= Q_W; k++) begin
                r_vs[k] <= r_vs[k-1];
            end
        end
    end

    assign w_dx[0] = r5_dx;
    assign w_dy[0] = r5_dy;

    // Divider chains, most significant quotient bit first.
    for (genvar b = 0; b < Q_W; b++) begin : g_div
        lpai_div_cell #(.BIT(Q_W - 1 - b)) u_div_x (
            .i_clk (i_clk), .i_en (w_adv), .i_div (w_dx[b]), .o_div (w_dx[b+1])
        );
        lpai_div_cell #(.BIT(Q_W - 1 - b)) u_div_y (
            .i_clk (i_clk), .i_en (w_adv), .i_div (w_dy[b]), .o_div (w_dy[b+1])
        );
    end

    // Vertex result; parallel lines return the start point of line A.
    always_comb begin
        w_lx = vtx_lane(r_vs[Q_W].x1, w_dx[Q_W].q, r_vs[Q_W].neg_x, r_vs[Q_W].big_x);
        w_ly = vtx_lane(r_vs[Q_W].y1, w_dy[Q_W].q, r_vs[Q_W].neg_y, r_vs[Q_W].big_y);
        if (r_vs[Q_W].has) begin
            n_vt = '{has: 1'b1, clip: w_lx.clip | w_ly.clip, vx: w_lx.v, vy: w_ly.v};
        end else begin
            n_vt = '{has: 1'b0, clip: 1'b0, vx: r_vs[Q_W].x1, vy: r_vs[Q_W].y1};
        end
    end

    // Delay the vertex to line up with the end of the CORDIC chain.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_vt[0] <= n_vt;
            for (int k = 1; k <= VTX_DLY; k++) begin
                r_vt[k] <= r_vt[k-1];
            end
        end
    end

    // Angle: unsigned pair angle, or B minus A wrapped once into (-180,180].
    always_comb begin
        if (r_mode) begin
            n_ang = round_ang(w_vb[ANG_PIPE-1].z - w_va[ANG_PIPE-1].z);
            if (n_ang > HALF_TURN) begin
                n_ang = n_ang - FULL_TURN;
            end else if (n_ang <= -HALF_TURN) begin
                n_ang = n_ang + FULL_TURN;
            end
        end else begin
            n_ang = round_ang(w_vb[ANG_PIPE-1].z);
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_o_angle <= n_ang[ANG_W-1:0];
            r_o_vtx   <= r_vt[VTX_DLY];
        end
    end

    assign o_angle          = r_o_angle;
    assign o_vertex_x       = r_o_vtx.vx;
    assign o_vertex_y       = r_o_vtx.vy;
    assign o_has_vertex     = r_o_vtx.has;
    assign o_vertex_clipped = r_o_vtx.clip;

    // Checks on the unit's own control and results.
    `LPAI_ASSERT_NR(a_rst_empties, i_clk, !i_rst_n |=> !o_valid)
    `LPAI_ASSERT(a_stall_holds_word, i_clk, i_rst_n, o_stall |-> o_valid)
    `LPAI_ASSERT(a_parallel_no_clip, i_clk, i_rst_n, o_valid && !o_has_vertex |-> !o_vertex_clipped)
    `LPAI_ASSERT(a_mode0_range, i_clk, i_rst_n, o_valid && !r_mode |-> ($signed(o_angle) >= 0 && $signed(o_angle) <= 23040))
    `LPAI_ASSERT(a_mode1_range, i_clk, i_rst_n, o_valid && r_mode |-> ($signed(o_angle) > -46080 && $signed(o_angle) <= 46080))

endmodule

@@ sim/line_pair_angle_intersect_unit_tb.sv @@
// Testbench for the line pair angle and intersection unit.
// Depends on lpai_pkg and the RTL of line_pair_angle_intersect_unit only.
`timescale 1ns / 1ps

module line_pair_angle_intersect_unit_tb;
    import lpai_pkg::*;

    // One word of two lines.
    typedef struct packed {
        logic signed [IN_W-1:0] ax1;
        logic signed [IN_W-1:0] ay1;
        logic signed [IN_W-1:0] ax2;
        logic signed [IN_W-1:0] ay2;
        logic signed [IN_W-1:0] bx1;
        logic signed [IN_W-1:0] by1;
        logic signed [IN_W-1:0] bx2;
        logic signed [IN_W-1:0] by2;
    } t_pair;

    // One result word.
    typedef struct packed {
        logic signed [ANG_W-1:0] ang;
        logic signed [IN_W-1:0]  vx;
        logic signed [IN_W-1:0]  vy;
        logic                    has;
        logic                    clip;
    } t_meet;

    localparam int DEG_ONE = 1 << ACC_FRAC;
    localparam int LIMIT   = 400000;

    logic i_clk, i_rst_n, i_cfg_we, i_cfg_wdata, i_valid, i_stall;
    logic o_stall, o_valid, o_has_vertex, o_vertex_clipped;
    logic signed [IN_W-1:0] i_a_start_x, i_a_start_y, i_a_end_x, i_a_end_y;
    logic signed [IN_W-1:0] i_b_start_x, i_b_start_y, i_b_end_x, i_b_end_y;
    logic signed [ANG_W-1:0] o_angle;
    logic signed [IN_W-1:0] o_vertex_x, o_vertex_y;

    t_pair pending_pairs[$];
    t_meet expected_meets[$];
    logic  signed_mode;
    int    send_idle_pct, recv_idle_pct, hold_off_cycles, cycle_count;
    int    errors;
    bit    driving;
    bit    in_taken;

    line_pair_angle_intersect_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_a_start_x(i_a_start_x), .i_a_start_y(i_a_start_y),
        .i_a_end_x(i_a_end_x), .i_a_end_y(i_a_end_y),
        .i_b_start_x(i_b_start_x), .i_b_start_y(i_b_start_y),
        .i_b_end_x(i_b_end_x), .i_b_end_y(i_b_end_y),
        .o_valid(o_valid), .i_stall(i_stall), .o_angle(o_angle),
        .o_vertex_x(o_vertex_x), .o_vertex_y(o_vertex_y),
        .o_has_vertex(o_has_vertex), .o_vertex_clipped(o_vertex_clipped)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Shift right rounding toward minus infinity.
    function automatic longint shr_floor(longint v, int s);
        return v >= 0 ? (v >>> s) : ~((~v) >>> s);
    endfunction

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    // Direction angle in 2^-20 degree by vectoring CORDIC.
    function automatic longint direction_deg(longint y, longint x);
        longint z, t, m, xs, ys;
        longint steps[CORDIC_STEPS];
        steps = '{47185920, 27855475, 14718068, 7471121, 3750058, 1876857, 938658,
                  469357, 234682, 117342, 58671, 29335, 14668, 7334, 3667, 1833,
                  917, 458, 229, 115, 57, 29, 14, 7};
        z = 0;
        if (y == 0) return x < 0 ? 180 * DEG_ONE : 0;
        if (x == 0) return y > 0 ? 90 * DEG_ONE : -90 * DEG_ONE;
        if (x < 0) begin
            t = x;
            if (y > 0) begin
                x = y; y = -t; z = 90 * DEG_ONE;
            end else begin
                x = -y; y = t; z = -90 * DEG_ONE;
            end
        end
        m = mag(x) > mag(y) ? mag(x) : mag(y);
        while (m < (64'sd1 <<< 40)) begin
            x = x * 2; y = y * 2; m = m * 2;
        end
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = shr_floor(x, i);
            ys = shr_floor(y, i);
            if (y > 0) begin
                x += ys; y -= xs; z += steps[i];
            end else begin
                x -= ys; y += xs; z -= steps[i];
            end
        end
        return z;
    endfunction

    function automatic longint to_angle_grid(longint z);
        return shr_floor(z + (64'sd1 <<< (ROUND_SH - 1)), ROUND_SH);
    endfunction

    // Nearest integer to p/d with halves away from zero, on 128 bits.
    function automatic longint round_quot(logic signed [127:0] p, longint d);
        logic [127:0] up, ud, q;
        up = p < 0 ? -p : p;
        ud = d < 0 ? -d : d;
        q  = (2 * up + ud) / (2 * ud);
        if (q > 128'd1 << 40) q = 128'd1 << 40;
        return ((p < 0) != (d < 0)) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamp_coord(longint v, inout logic clip);
        if (v > 524287) begin
            clip = 1'b1; return 524287;
        end
        if (v < -524288) begin
            clip = 1'b1; return -524288;
        end
        return v;
    endfunction

    // Expected angle and vertex of one line pair.
    function automatic t_meet predict_meet(t_pair p, logic mode);
        t_meet  r;
        longint x1, y1, x2, y2, x3, y3, x4, y4, vax, vay, vbx, vby;
        longint d, den, num, dot, crs;
        logic   clip;
        x1 = p.ax1; y1 = p.ay1; x2 = p.ax2; y2 = p.ay2;
        x3 = p.bx1; y3 = p.by1; x4 = p.bx2; y4 = p.by2;
        vax = x2 - x1; vay = y2 - y1; vbx = x4 - x3; vby = y4 - y3;
        if (mode) begin
            d = to_angle_grid(direction_deg(vby, vbx) - direction_deg(vay, vax));
            if (d > 180 * 256) d -= 360 * 256;
            else if (d <= -180 * 256) d += 360 * 256;
        end else if ((vax == 0 && vay == 0) || (vbx == 0 && vby == 0)) begin
            d = 0;
        end else begin
            dot = vax * vbx + vay * vby;
            crs = vax * vby - vay * vbx;
            d = to_angle_grid(direction_deg(mag(crs), mag(dot)));
        end
        r.ang = d[ANG_W-1:0];
        clip = 1'b0;
        den = (x1 - x2) * (y3 - y4) - (y1 - y2) * (x3 - x4);
        if (den == 0) begin
            r.vx = x1[IN_W-1:0];
            r.vy = y1[IN_W-1:0];
            r.has = 1'b0;
        end else begin
            num = (x1 - x3) * (y3 - y4) - (y1 - y3) * (x3 - x4);
            d = clamp_coord(x1 + round_quot(128'(num) * 128'(vax), den), clip);
            r.vx = d[IN_W-1:0];
            d = clamp_coord(y1 + round_quot(128'(num) * 128'(vay), den), clip);
            r.vy = d[IN_W-1:0];
            r.has = 1'b1;
        end
        r.clip = clip;
        return r;
    endfunction

    function automatic logic signed [IN_W-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 1) ? V_MAX : V_MIN;
            1: return IN_W'($signed($urandom_range(0, 64)) - 32);
            2: return IN_W'($signed($urandom_range(0, 8000)) - 4000);
            default: return IN_W'($urandom);
        endcase
    endfunction

    function automatic t_pair rand_pair();
        t_pair p;
        p.ax1 = rand_coord(); p.ay1 = rand_coord();
        p.ax2 = rand_coord(); p.ay2 = rand_coord();
        p.bx1 = rand_coord(); p.by1 = rand_coord();
        p.bx2 = rand_coord(); p.by2 = rand_coord();
        case ($urandom_range(0, 9))
            0: begin // parallel: B is A shifted
                p.bx2 = p.bx1 + p.ax2 - p.ax1; p.by2 = p.by1 + p.ay2 - p.ay1;
            end
            1: begin // zero length line
                p.bx2 = p.bx1; p.by2 = p.by1;
            end
            2: begin // axis aligned
                p.ay2 = p.ay1; p.bx2 = p.bx1;
            end
            default: ;
        endcase
        return p;
    endfunction

    // Records whether the input word was taken at this rising edge.
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_valid && !o_stall;
    end

    // Driver: offers the next pending word whenever the sender is not idling.
    always @(negedge i_clk) begin
        if (in_taken) begin
            expected_meets.push_back(predict_meet(
                {i_a_start_x, i_a_start_y, i_a_end_x, i_a_end_y,
                 i_b_start_x, i_b_start_y, i_b_end_x, i_b_end_y}, signed_mode));
            void'(pending_pairs.pop_front());
        end
        if (i_valid && !in_taken) begin
            // Stalled word stays on the port.
        end else if (driving && pending_pairs.size() > 0
                     && $urandom_range(0, 99) >= send_idle_pct) begin
            i_valid <= 1'b1;
            {i_a_start_x, i_a_start_y, i_a_end_x, i_a_end_y,
             i_b_start_x, i_b_start_y, i_b_end_x, i_b_end_y} <= pending_pairs[0];
        end else begin
            i_valid <= 1'b0;
        end
    end

    // Receiver: random idling, or a long hold-off counted down cycle by cycle.
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            i_stall <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Monitor: checks each accepted result word against the oldest expectation.
    always @(posedge i_clk) begin
        t_meet got, want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            got = {o_angle, o_vertex_x, o_vertex_y, o_has_vertex, o_vertex_clipped};
            if (expected_meets.size() == 0) begin
                $display("%0t: unexpected result word %h", $time, got);
                errors <= errors + 1;
            end else begin
                want = expected_meets.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected ang=%0d vx=%0d vy=%0d has=%b clip=%b",
                             $time, want.ang, want.vx, want.vy, want.has, want.clip);
                    $display("%0t:          actual   ang=%0d vx=%0d vy=%0d has=%b clip=%b",
                             $time, got.ang, got.vx, got.vy, got.has, got.clip);
                    errors <= errors + 1;
                end
            end
        end
    end

    // Timeout watchdog.
    always @(posedge i_clk) begin
        if (cycle_count > LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Waits until every queued word is sent and every result is back.
    task automatic drain();
        while (pending_pairs.size() > 0 || expected_meets.size() > 0 || i_valid)
            @(posedge i_clk);
        repeat (LAT + 5) @(posedge i_clk);
    endtask

    task automatic write_mode(logic m);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        signed_mode = m;
    endtask

    task automatic load_directed();
        t_pair p;
        p = '0;
        pending_pairs.push_back(p);
        p = '{0, 0, 160, 0, 0, -80, 0, 80};
        pending_pairs.push_back(p);
        p = '{0, 0, -160, 0, 0, 0, 160, 0};
        pending_pairs.push_back(p);
        p = '{0, 0, 16, 16, 0, 16, 16, 0};
        pending_pairs.push_back(p);
        p = '{0, 0, 0, 16, 5, 5, 5, -7};
        pending_pairs.push_back(p);
        p = '{V_MIN, V_MIN, V_MAX, V_MAX, V_MIN, V_MAX, V_MAX, V_MIN};
        pending_pairs.push_back(p);
        p = '{0, 0, 1, 0, V_MAX, V_MIN, V_MAX - 1, V_MIN + 1};
        pending_pairs.push_back(p);
        p = '{0, 0, 1, 1, 100, 0, 101, 2};
        pending_pairs.push_back(p);
        p = '{V_MAX, V_MAX, V_MIN, V_MIN, 3, 3, 3, 3};
        pending_pairs.push_back(p);
        p = '{0, 0, -16, 0, 0, 0, -16, -1};
        pending_pairs.push_back(p);
        p = '{0, 0, -16, 0, 0, 0, -16, 1};
        pending_pairs.push_back(p);
        p = '{1, 0, 0, 0, 0, 1, 0, 0};
        pending_pairs.push_back(p);
        p = '{0, 0, 3, 0, 1, 1, 2, 2};
        pending_pairs.push_back(p);
        p = '{0, 0, 0, 3, 1, 1, 2, -2};
        pending_pairs.push_back(p);
    endtask

    initial begin
        i_rst_n = 1'b0; i_cfg_we = 1'b0; i_cfg_wdata = 1'b0;
        i_valid = 1'b0; i_stall = 1'b0;
        {i_a_start_x, i_a_start_y, i_a_end_x, i_a_end_y,
         i_b_start_x, i_b_start_y, i_b_end_x, i_b_end_y} = '0;
        signed_mode = 1'b0; send_idle_pct = 0; recv_idle_pct = 0;
        hold_off_cycles = 0; cycle_count = 0; errors = 0; driving = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed words in both modes, starting from the reset mode.
        load_directed();
        driving = 1'b1;
        drain();
        write_mode(1'b1);
        load_directed();
        drain();

        // Random phases with varying mode and idling; the sender pauses between.
        for (int ph = 0; ph < 6; ph++) begin
            write_mode(ph % 2 == 0 ? 1'b0 : 1'b1);
            send_idle_pct = ph < 2 ? 16 : (ph < 4 ? 46 : 0);
            recv_idle_pct = ph < 2 ? 46 : (ph < 4 ? 16 : 0);
            if (ph == 4) hold_off_cycles = 120;
            for (int k = 0; k < 105; k++) pending_pairs.push_back(rand_pair());
            drain();
        end
        send_idle_pct = 0; recv_idle_pct = 0;
        drain();

        if (errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
